>>> hdl/cscd_pkg.sv
// cscd_pkg: shared widths, constants, codes and types of the degree-input cordic sine/cosine
// block, plus the arctangent table in binary angle units
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cscd_pkg;

    localparam int ANGLE_W    = 16;
    localparam int DATA_W     = 16;
    localparam int ITER_W     = 5;
    localparam int ATAN_MAX   = 16;
    localparam int ATAN_IDX_W = 4;

    localparam logic [ITER_W-1:0] ITER_RESET = 5'd13;
    localparam logic [DATA_W-1:0] X_START    = 16'h4DBA;

    localparam int TURN_DEG    = 360;
    localparam int HALF_DEG    = 180;
    localparam int QUART_DEG   = 90;
    localparam int EIGHTH_DEG  = 45;

    // floor(u / 360) = (u * RECIP_360) >> RECIP_360_SHIFT for 16-bit u
    localparam int RECIP_360_W     = 17;
    localparam int RECIP_360_SHIFT = 25;
    localparam logic [RECIP_360_W-1:0] RECIP_360 = 17'd93207;
    // (-32768) mod 360, offset of the biased angle
    localparam logic [8:0] TURN_OFFSET = 9'd352;

    // floor(m * 1024 / 45) = (m * RECIP_45) >> RECIP_45_SHIFT for m <= 45
    localparam int RECIP_45_W     = 21;
    localparam int RECIP_45_SHIFT = 16;
    localparam logic [RECIP_45_W-1:0] RECIP_45 = 21'd1491309;

    // octant fold codes
    localparam logic [1:0] OCT_NONE = 2'd0;
    localparam logic [1:0] OCT_POS  = 2'd1;
    localparam logic [1:0] OCT_NEG  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] theta;
        logic                     flip;
        logic [1:0]               oct;
    } rot_t;

    function automatic logic [DATA_W-1:0] atan_units(input logic [ATAN_IDX_W-1:0] idx);
        logic [DATA_W-1:0] val;
        case (idx)
            4'd0:    val = 16'h4000;
            4'd1:    val = 16'h25C8;
            4'd2:    val = 16'h13F6;
            4'd3:    val = 16'h0A22;
            4'd4:    val = 16'h0516;
            4'd5:    val = 16'h028B;
            4'd6:    val = 16'h0145;
            4'd7:    val = 16'h00A2;
            4'd8:    val = 16'h0051;
            4'd9:    val = 16'h0029;
            4'd10:   val = 16'h0014;
            4'd11:   val = 16'h000A;
            4'd12:   val = 16'h0005;
            4'd13:   val = 16'h0003;
            4'd14:   val = 16'h0002;
            default: val = 16'h0001;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> hdl/cordic_sine_cosine_degrees_top.sv
// cordic sine and cosine of an angle in whole degrees, Q1.15 results
// input stream: s_axis_tdata[15:0] = angle (signed degrees)
// output stream: m_axis_tdata[15:0] = sine_value, [31:16] = cosine_value
// config: cfg_wr_en / cfg_wr_data write iteration_count (reset 13), counts above
//   ARCTAN_TABLE_SIZE run every step; write only while no item is in flight
// latency: ARCTAN_TABLE_SIZE + 7 cycles from accept to output valid (23 at the
//   default), set by six conditioning stages, one register per rotation step
//   and the output register
// throughput: one item per cycle, every stage is a register with its own valid
// stall: each stage holds while the one after it is full and blocked, so
//   bubbles close up and input is still taken while a result waits at the output
// reset: all valid bits cleared, iteration_count back to 13, no clearing pass
// depends on cscd_pkg, cscd_front, cscd_rot_stage
`timescale 1ns / 1ps
`default_nettype none

module cordic_sine_cosine_degrees_top
    import cscd_pkg::*;
#(
    parameter int ARCTAN_TABLE_SIZE = ATAN_MAX
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [ITER_W-1:0]   cfg_wr_data,     // iteration_count
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [ANGLE_W-1:0]  s_axis_tdata,    // [15:0] angle
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [2*DATA_W-1:0] m_axis_tdata     // [15:0] sine_value, [31:16] cosine_value
);

    localparam int N = ARCTAN_TABLE_SIZE;

    // per-step enable mask, thermometer coded from the iteration count
    logic [N-1:0] step_on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                step_on_reg[i] <= (ITER_W'(i) < ITER_RESET);
            end
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < N; i++)
            begin
                step_on_reg[i] <= (ITER_W'(i) < cfg_wr_data);
            end
        end
    end

    logic [N:0] bus_vld;
    logic [N:0] bus_rdy;
    rot_t       bus [N+1];

    cscd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_angle  ($signed(s_axis_tdata)),
        .out_valid (bus_vld[0]),
        .out_ready (bus_rdy[0]),
        .out_data  (bus[0])
    );

    for (genvar g = 0; g < N; g++)
    begin : g_rot
        cscd_rot_stage #(
            .STAGE (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (step_on_reg[g]),
            .in_valid  (bus_vld[g]),
            .in_ready  (bus_rdy[g]),
            .in_data   (bus[g]),
            .out_valid (bus_vld[g+1]),
            .out_ready (bus_rdy[g+1]),
            .out_data  (bus[g+1])
        );
    end

    // output stage: cosine magnitude, octant swap, quadrant sign
    logic                     out_vld_reg;
    logic                     out_en;
    logic signed [DATA_W-1:0] x_abs, sn_oct, cs_oct;
    logic [2*DATA_W-1:0]      out_data_reg, out_data_next;
    rot_t                     fin;

    assign fin          = bus[N];
    assign out_en       = !out_vld_reg || m_axis_tready;
    assign bus_rdy[N]   = out_en;

    always_comb
    begin
        x_abs = fin.x[DATA_W-1] ? -fin.x : fin.x;
        case (fin.oct)
            OCT_POS:
            begin
                sn_oct = x_abs;
                cs_oct = -fin.y;
            end
            OCT_NEG:
            begin
                sn_oct = -x_abs;
                cs_oct = fin.y;
            end
            default:
            begin
                sn_oct = fin.y;
                cs_oct = x_abs;
            end
        endcase
        if (fin.flip)
        begin
            out_data_next = {DATA_W'(-cs_oct), DATA_W'(-sn_oct)};
        end
        else
        begin
            out_data_next = {DATA_W'(cs_oct), DATA_W'(sn_oct)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_vld_reg <= bus_vld[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // an empty output register lets every stage advance
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_axis_tready)
        else $error("input blocked while output register empty");

    // enabled steps always form a prefix
    a_step_mask_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((step_on_reg + N'(1)) & step_on_reg) == '0)
        else $error("rotation step mask has a hole");

    // scaled angle entering the rotator stays within one octant
    a_octant_range: assert property (@(posedge clk) disable iff (!rst_n)
        bus_vld[0] |-> (bus[0].theta <= 16'sd16384 && bus[0].theta >= -16'sd16384))
        else $error("folded angle out of octant range");
`endif

endmodule

`default_nettype wire

>>> hdl/cscd_front.sv
// cscd_front: six-stage angle conditioning, mod-360 reduction, quadrant and octant folding
// and scaling from degrees to binary angle units
// depends on cscd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cscd_front
    import cscd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [ANGLE_W-1:0] in_angle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rot_t                      out_data
);

    localparam int NSTAGE = 6;
    localparam int Q_W    = 8;
    localparam int R_W    = 9;
    localparam int SUM_W  = 10;
    localparam int TH_W   = 10;
    localparam int FOLD_W = 7;
    localparam int MAG_W  = 6;
    localparam int SQ_W   = 11;
    localparam int SCL_W  = 15;
    localparam int P360_W = ANGLE_W + RECIP_360_W;
    localparam int P45_W  = MAG_W + RECIP_45_W;

    localparam logic signed [TH_W-1:0] HALF_S   = TH_W'(HALF_DEG);
    localparam logic signed [TH_W-1:0] QUART_S  = TH_W'(QUART_DEG);
    localparam logic signed [TH_W-1:0] EIGHTH_S = TH_W'(EIGHTH_DEG);

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_next  = {vld_reg[NSTAGE-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // stage 1: bias to unsigned, quotient by 360
    logic [ANGLE_W-1:0] u1_reg, u1_next;
    logic [Q_W-1:0]     q1_reg, q1_next;
    logic [P360_W-1:0]  prod360;

    assign u1_next = {~in_angle[ANGLE_W-1], in_angle[ANGLE_W-2:0]};
    assign prod360 = P360_W'(u1_next) * P360_W'(RECIP_360);
    assign q1_next = prod360[RECIP_360_SHIFT +: Q_W];

    // stage 2: remainder of the biased angle
    logic [ANGLE_W:0] q_turn;
    logic [ANGLE_W:0] diff2;
    logic [R_W-1:0]   r2_reg, r2_next;

    assign q_turn  = (ANGLE_W+1)'(q1_reg) * (ANGLE_W+1)'(TURN_DEG);
    assign diff2   = {1'b0, u1_reg} - q_turn;
    assign r2_next = diff2[R_W-1:0];

    // stage 3: undo bias, map into -179..180
    logic [SUM_W-1:0]       sum3, red3;
    logic signed [TH_W-1:0] th3_reg, th3_next;

    always_comb
    begin
        sum3 = {1'b0, r2_reg} + SUM_W'(TURN_OFFSET);
        red3 = (sum3 >= SUM_W'(TURN_DEG)) ? sum3 - SUM_W'(TURN_DEG) : sum3;
        th3_next = (red3 > SUM_W'(HALF_DEG)) ? $signed(red3 - SUM_W'(TURN_DEG))
                                             : $signed(red3);
    end

    // stage 4: quadrant and octant fold
    logic signed [TH_W-1:0]   t4a, t4b;
    logic signed [FOLD_W-1:0] t4_reg, t4_next;
    logic                     flip4_reg, flip4_next;
    logic [1:0]               oct4_reg, oct4_next;

    always_comb
    begin
        if (th3_reg < -HALF_S + QUART_S)
        begin
            t4a        = th3_reg + HALF_S;
            flip4_next = 1'b1;
        end
        else if (th3_reg > QUART_S)
        begin
            t4a        = th3_reg - HALF_S;
            flip4_next = 1'b1;
        end
        else
        begin
            t4a        = th3_reg;
            flip4_next = 1'b0;
        end
        if (t4a < -EIGHTH_S)
        begin
            t4b       = t4a + QUART_S;
            oct4_next = OCT_NEG;
        end
        else if (t4a > EIGHTH_S)
        begin
            t4b       = t4a - QUART_S;
            oct4_next = OCT_POS;
        end
        else
        begin
            t4b       = t4a;
            oct4_next = OCT_NONE;
        end
        t4_next = t4b[FOLD_W-1:0];
    end

    // stage 5: magnitude scaled to binary angle units
    logic [FOLD_W-1:0] abs5;
    logic [P45_W-1:0]  prod45;
    logic [SQ_W-1:0]   sq5;
    logic [SCL_W-1:0]  mag5_reg, mag5_next;
    logic              neg5_reg, flip5_reg;
    logic [1:0]        oct5_reg;

    always_comb
    begin
        abs5      = t4_reg[FOLD_W-1] ? FOLD_W'(-t4_reg) : FOLD_W'(t4_reg);
        prod45    = P45_W'(abs5[MAG_W-1:0]) * P45_W'(RECIP_45);
        sq5       = prod45[RECIP_45_SHIFT +: SQ_W];
        mag5_next = {sq5, 4'b0000};
    end

    // stage 6: sign restore, cordic start vector
    logic [DATA_W-1:0] mag6;
    rot_t              rot6_reg, rot6_next;

    always_comb
    begin
        mag6            = DATA_W'(mag5_reg);
        rot6_next.x     = $signed(X_START);
        rot6_next.y     = '0;
        rot6_next.acc   = '0;
        rot6_next.theta = neg5_reg ? $signed(-mag6) : $signed(mag6);
        rot6_next.flip  = flip5_reg;
        rot6_next.oct   = oct5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u1_reg <= u1_next;
            q1_reg <= q1_next;
        end
        if (en[1])
        begin
            r2_reg <= r2_next;
        end
        if (en[2])
        begin
            th3_reg <= th3_next;
        end
        if (en[3])
        begin
            t4_reg    <= t4_next;
            flip4_reg <= flip4_next;
            oct4_reg  <= oct4_next;
        end
        if (en[4])
        begin
            mag5_reg  <= mag5_next;
            neg5_reg  <= t4_reg[FOLD_W-1];
            flip5_reg <= flip4_reg;
            oct5_reg  <= oct4_reg;
        end
        if (en[5])
        begin
            rot6_reg <= rot6_next;
        end
    end

    assign out_data = rot6_reg;

endmodule

`default_nettype wire

>>> hdl/cscd_rot_stage.sv
// cscd_rot_stage: one registered cordic rotation step with its own valid and stall logic
// depends on cscd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cscd_rot_stage
    import cscd_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic active,
    input  logic in_valid,
    output logic in_ready,
    input  rot_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rot_t out_data
);

    logic                     vld_reg;
    rot_t                     rot_reg, rot_next;
    logic signed [DATA_W-1:0] x_sh, y_sh, atan;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = rot_reg;

    always_comb
    begin
        x_sh     = in_data.x >>> STAGE;
        y_sh     = in_data.y >>> STAGE;
        atan     = $signed(atan_units(ATAN_IDX_W'(STAGE)));
        rot_next = in_data;
        if (active)
        begin
            if (in_data.theta > in_data.acc)
            begin
                rot_next.x   = in_data.x - y_sh;
                rot_next.y   = in_data.y + x_sh;
                rot_next.acc = in_data.acc + atan;
            end
            else
            begin
                rot_next.x   = in_data.x + y_sh;
                rot_next.y   = in_data.y - x_sh;
                rot_next.acc = in_data.acc - atan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rot_reg <= rot_next;
        end
    end

endmodule

`default_nettype wire

>>> bench/sincos_checker.sv
// sincos_checker: watches the angle, result and config ports of the cordic sine/cosine block,
// predicts sine and cosine for every accepted angle and compares each result in order
// depends on cscd_pkg
`timescale 1ns / 1ps

module sincos_checker
    import cscd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [ITER_W-1:0]   cfg_wr_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [ANGLE_W-1:0]  s_axis_tdata,    // [15:0] angle
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [2*DATA_W-1:0] m_axis_tdata,    // [15:0] sine_value, [31:16] cosine_value
    output int                  error_count,
    output int                  pending_count
);

    typedef struct packed {
        logic signed [DATA_W-1:0]  sine;
        logic signed [DATA_W-1:0]  cosine;
        logic signed [ANGLE_W-1:0] angle;
    } sincos_t;

    // rotation angles in binary units, step 0 in the lowest slice
    localparam logic [16*DATA_W-1:0] ROT_ANGLES = {
        16'h0001, 16'h0002, 16'h0003, 16'h0005, 16'h000A, 16'h0014, 16'h0029, 16'h0051,
        16'h00A2, 16'h0145, 16'h028B, 16'h0516, 16'h0A22, 16'h13F6, 16'h25C8, 16'h4000
    };

    logic [ITER_W-1:0] iter_cfg;
    sincos_t           expected_sincos[$];

    function automatic sincos_t predict_sincos(input logic signed [ANGLE_W-1:0] angle,
                                               input logic [ITER_W-1:0] iters);
        int                       deg;
        int                       mag;
        int                       steps;
        bit                       flip;
        logic [1:0]               octant;
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] x_next;
        sincos_t                  res;
        deg = angle;
        while (deg < -180)
            deg += 360;
        while (deg > 180)
            deg -= 360;
        // half-turn fold flips both signs
        flip = 1'b0;
        if (deg < -90)
        begin
            deg += 180;
            flip = 1'b1;
        end
        else if (deg > 90)
        begin
            deg -= 180;
            flip = 1'b1;
        end
        // quarter-turn fold swaps sine and cosine
        octant = OCT_NONE;
        if (deg < -45)
        begin
            deg += 90;
            octant = OCT_NEG;
        end
        else if (deg > 45)
        begin
            deg -= 90;
            octant = OCT_POS;
        end
        mag = (deg < 0) ? -deg : deg;
        mag = ((mag * 1024) / 45) * 16;
        target = (deg < 0) ? -mag : mag;
        steps = (iters > ATAN_MAX) ? ATAN_MAX : iters;
        x = X_START;
        y = '0;
        acc = '0;
        for (int i = 0; i < steps; i++)
        begin
            if (int'(target) - int'(acc) > 0)
            begin
                x_next = x - (y >>> i);
                y = y + (x >>> i);
                acc = acc + $signed(ROT_ANGLES[i*DATA_W +: DATA_W]);
            end
            else
            begin
                x_next = x + (y >>> i);
                y = y - (x >>> i);
                acc = acc - $signed(ROT_ANGLES[i*DATA_W +: DATA_W]);
            end
            x = x_next;
        end
        if (x < 0)
            x = -x;
        if (octant == OCT_POS)
        begin
            res.sine = x;
            res.cosine = -y;
        end
        else if (octant == OCT_NEG)
        begin
            res.sine = -x;
            res.cosine = y;
        end
        else
        begin
            res.sine = y;
            res.cosine = x;
        end
        if (flip)
        begin
            res.sine = -res.sine;
            res.cosine = -res.cosine;
        end
        res.angle = angle;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sincos_t want;
        if (!rst_n)
        begin
            iter_cfg = ITER_RESET;
            expected_sincos.delete();
            pending_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_sincos.push_back(predict_sincos(s_axis_tdata, iter_cfg));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sincos.size() == 0)
                begin
                    if (error_count < 10)
                        $display("[%0t] unexpected item: sine %0d cosine %0d", $realtime,
                                 $signed(m_axis_tdata[DATA_W-1:0]),
                                 $signed(m_axis_tdata[2*DATA_W-1:DATA_W]));
                    error_count++;
                end
                else
                begin
                    want = expected_sincos.pop_front();
                    if (m_axis_tdata[DATA_W-1:0] !== want.sine
                        || m_axis_tdata[2*DATA_W-1:DATA_W] !== want.cosine)
                    begin
                        if (error_count < 10)
                            $display(
                                "[%0t] angle %0d: exp sin %0d cos %0d, got sin %0d cos %0d",
                                $realtime, want.angle, want.sine, want.cosine,
                                $signed(m_axis_tdata[DATA_W-1:0]),
                                $signed(m_axis_tdata[2*DATA_W-1:DATA_W]));
                        error_count++;
                    end
                end
            end
            if (cfg_wr_en)
                iter_cfg = cfg_wr_data;
            pending_count = expected_sincos.size();
        end
    end

endmodule

>>> bench/tb_cordic_sine_cosine_degrees_top.sv
// tb_cordic_sine_cosine_degrees_top: drives angles and iteration counts into the cordic
// sine/cosine block with random gaps and stalls, and gives the verdict
// depends on cscd_pkg, cordic_sine_cosine_degrees_top, sincos_checker
`timescale 1ns / 1ps

module tb_cordic_sine_cosine_degrees_top;
    import cscd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 120;
    localparam int LONG_HOLD     = 150;
    localparam int TAIL_CYCLES   = 30;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [ITER_W-1:0]   cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [ANGLE_W-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [2*DATA_W-1:0] m_axis_tdata;

    int   error_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   rx_holding;
    event rx_hold_ev;

    int corner_angles[25] = '{0, 1, -1, 44, 45, 46, -45, -46, 89, 90, 91, -90, -91,
                              135, 136, -136, 180, -180, 181, -181, 270, -270, 360,
                              32767, -32768};
    int iter_settings[9] = '{16, 0, 31, 1, 12, 17, 2, 8, 15};
    int fold_edges[4] = '{45, 90, 135, 180};

    cordic_sine_cosine_degrees_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sincos_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver side
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_holding || !rst_n)
                m_axis_tready = 1'b0;
            else
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off
    initial
    begin
        rx_holding = 1'b0;
        forever
        begin
            @(rx_hold_ev);
            @(posedge clk);
            rx_holding = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            rx_holding = 1'b0;
        end
    end

    task automatic send_angle(input logic [ANGLE_W-1:0] angle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = ANGLE_W'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = angle;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_iterations(input int count);
        cfg_wr_en = 1'b1;
        cfg_wr_data = ITER_W'(count);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial
    begin : stimulus
        int angle;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 6;
        recv_idle_pct = 78;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners at the reset iteration count
        foreach (corner_angles[k])
            send_angle(ANGLE_W'(corner_angles[k]));

        for (int phase = 0; phase < 9; phase++)
        begin
            wait_drained();
            write_iterations(iter_settings[phase]);
            if (phase / 3 == 0)
            begin
                send_idle_pct = 6;
                recv_idle_pct = 78;
            end
            else if (phase / 3 == 1)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 6;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 6)
                -> rx_hold_ev;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender pause until the pipeline is empty
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                case ($urandom_range(3))
                    0: angle = $signed(16'($urandom));
                    1: angle = $urandom_range(720) - 360;
                    2: angle = $urandom_range(90) - 45;
                    default:
                    begin
                        angle = fold_edges[$urandom_range(3)] + $urandom_range(2) - 1;
                        if ($urandom_range(1))
                            angle = -angle;
                        angle += 360 * ($urandom_range(6) - 3);
                    end
                endcase
                send_angle(ANGLE_W'(angle));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
